[sv/prf_pkg.sv]
`default_nettype none
package prf_pkg;
  localparam int unsigned GridW = 64;
  localparam int unsigned GridH = 64;
  localparam int unsigned RowW  = $clog2(GridH);

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatNeg  = 2'd1;
  localparam logic [1:0] StatSame = 2'd2;

  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic        command;
    logic [6:0]  coord_x;
    logic [6:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [5:0]  row_number;
    logic [1:0]  status;
    logic        last_row;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture vertex, set up segment
    logic div;       // one step of the y increment divide
    logic step;      // plot next interior point
    logic finish;    // plot endpoint, update prev
    logic start;     // load row counter with y extent
    logic err_neg;
    logic err_same;
    logic rd;        // read row at row counter
    logic emit;      // load output register
    logic clr;       // clear one row, advance counter
    logic clr_start;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic neg;
    logic same;
    logic div_done;
    logic seg_done;
    logic err;
    logic row_zero;
    logic clr_done;
  } dp_stat_t;
endpackage
`default_nettype wire

[sv/prf_if.sv]
`default_nettype none
interface prf_in_if;
  import prf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prf_out_if;
  import prf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/polyline_raster_fill_unit.sv]
`default_nettype none
// Vertex: accept, a restoring divide for the y step, then n-1 interior
// pixels and the endpoint, one per cycle (n = |dx|, or |dy| if dx is 0).
// Rejected or ignored vertex: taken with no other work. Finish: accept, then
// a read and an output register load per row plus receiver stalls, a wait for
// the last transfer, then a frame clear of all rows. Error finish: one result.
// Reset: async active low; a frame clear of all rows follows, no item taken.
module polyline_raster_fill_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prf_in_if.sink    in_if,
  prf_out_if.source out_if
);
  import prf_pkg::*;

  // Controller drives datapath commands; datapath reports status back.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  prf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_cmd_i   (in_if.data.command),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath holds the frame memory, segment stepper and output register.
  prf_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(in_if.data),
    .cmd_i (cmd),
    .stat_o(stat),
    .out_o (out_if.data)
  );
endmodule
`default_nettype wire

[sv/prf_datapath.sv]
`default_nettype none
module prf_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prf_pkg::in_item_t  item_i,
  input  wire prf_pkg::dp_cmd_t   cmd_i,
  output prf_pkg::dp_stat_t       stat_o,
  output prf_pkg::out_item_t      out_o
);
  import prf_pkg::*;

  logic [63:0] mem_q [GridH];
  logic [63:0] rd_q;

  logic [5:0] prev_x_q, prev_y_q, ext_x_q, ext_y_q;
  logic       have_q;
  logic [1:0] err_q;
  logic [5:0] tx_q, ty_q, ex_q, ey_q;
  logic [6:0] cnt_q;        // remaining points to plot, endpoint included
  logic [1:0] sx_q;         // -1,0,+1 as 2-bit signed
  logic [5:0] sy_q;         // |dy| / n, shifted in by the divider
  logic       sy_neg_q;
  logic [5:0] dv_rem_q;
  logic [5:0] dv_num_q;
  logic [2:0] dv_cnt_q;
  logic [6:0] row_q;        // row counter (read/clear)

  logic signed [7:0] dx, dy;
  logic [6:0] adx, ady, n;
  logic [5:0] nx, ny, sy_inc;
  logic [6:0] rem_sh, den;
  logic       q_bit;

  assign dx  = $signed({1'b0, item_i.coord_x}) - $signed({2'b0, prev_x_q});
  assign dy  = $signed({1'b0, item_i.coord_y}) - $signed({2'b0, prev_y_q});
  assign adx = dx[7] ? 7'(-dx) : dx[6:0];
  assign ady = dy[7] ? 7'(-dy) : dy[6:0];
  assign n   = (adx != 7'd0) ? adx : ady;

  // restoring divide |dy| / n, one quotient bit per cycle
  assign rem_sh = {dv_rem_q, dv_num_q[5]};
  assign den    = {1'b0, cnt_q[5:0]};
  assign q_bit  = (rem_sh >= den);

  assign sy_inc = sy_neg_q ? 6'(-sy_q) : sy_q;
  assign nx = tx_q + {{4{sx_q[1]}}, sx_q};
  assign ny = ty_q + sy_inc;

  assign stat_o.neg      = item_i.coord_x[6] | item_i.coord_y[6];
  assign stat_o.same     = have_q && (dx == 8'sd0) && (dy == 8'sd0);
  assign stat_o.div_done = (dv_cnt_q == 3'd1);
  assign stat_o.seg_done = (cnt_q <= 7'd1);
  assign stat_o.err      = (err_q != StatOk);
  assign stat_o.row_zero = (row_q == 7'd0);
  assign stat_o.clr_done = (row_q == 7'(GridH - 1));

  // write port: one pixel set or one row clear per cycle
  logic       pw;
  logic [5:0] wa, wb;
  always_comb begin
    pw = 1'b0;
    wa = ey_q;
    wb = ex_q;
    if (cmd_i.step) begin
      pw = 1'b1;
      wa = ny;
      wb = nx;
    end else if (cmd_i.finish) begin
      pw = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mem_q[row_q[5:0]] <= '0;
    else if (pw) mem_q[wa][wb] <= 1'b1;
    if (cmd_i.rd) rd_q <= mem_q[row_q[5:0]];
  end

  // span fill of the read row
  logic [63:0] lo_m, hi_m;
  always_comb begin
    lo_m = rd_q;
    hi_m = rd_q;
    for (int i = 1; i < 64; i++) begin
      lo_m[i]      = lo_m[i] | lo_m[i-1];
      hi_m[63-i]   = hi_m[63-i] | hi_m[64-i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.row_pixels <= stat_o.err ? 64'd0 : (lo_m & hi_m);
      out_o.row_number <= stat_o.err ? 6'd0 : row_q[5:0];
      out_o.status     <= err_q;
      out_o.last_row   <= stat_o.err | stat_o.row_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0; prev_y_q <= '0; ext_x_q <= '0; ext_y_q <= '0;
      have_q <= 1'b0; err_q <= StatOk; cnt_q <= '0; row_q <= '0;
      tx_q <= '0; ty_q <= '0; ex_q <= '0; ey_q <= '0; sx_q <= '0; sy_q <= '0;
      sy_neg_q <= 1'b0; dv_rem_q <= '0; dv_num_q <= '0; dv_cnt_q <= '0;
    end else begin
      if (cmd_i.err_neg)  err_q <= StatNeg;
      if (cmd_i.err_same) err_q <= StatSame;
      if (cmd_i.load) begin
        ex_q <= item_i.coord_x[5:0];
        ey_q <= item_i.coord_y[5:0];
        tx_q <= prev_x_q;
        ty_q <= prev_y_q;
        cnt_q <= have_q ? n : 7'd0;
        sx_q <= (adx == 7'd0) ? 2'b00 : (adx == n) ? (dx[7] ? 2'b11 : 2'b01) : 2'b00;
        sy_q <= '0;
        sy_neg_q <= dy[7];
        dv_rem_q <= '0;
        dv_num_q <= ady[5:0];
        dv_cnt_q <= 3'd6;          // six quotient bits
        if (item_i.coord_x[5:0] > ext_x_q) ext_x_q <= item_i.coord_x[5:0];
        if (item_i.coord_y[5:0] > ext_y_q) ext_y_q <= item_i.coord_y[5:0];
      end
      if (cmd_i.div) begin
        dv_rem_q <= q_bit ? 6'(rem_sh - den) : rem_sh[5:0];
        dv_num_q <= {dv_num_q[4:0], 1'b0};
        sy_q     <= {sy_q[4:0], q_bit};
        dv_cnt_q <= dv_cnt_q - 3'd1;
      end
      if (cmd_i.step) begin
        tx_q <= nx; ty_q <= ny; cnt_q <= cnt_q - 7'd1;
      end
      if (cmd_i.finish) begin
        prev_x_q <= ex_q; prev_y_q <= ey_q; have_q <= 1'b1;
      end
      if (cmd_i.start) row_q <= {1'b0, ext_y_q};
      if (cmd_i.emit && !stat_o.row_zero) row_q <= row_q - 7'd1;
      if (cmd_i.clr_start) begin
        row_q <= '0; prev_x_q <= '0; prev_y_q <= '0; have_q <= 1'b0;
        ext_x_q <= '0; ext_y_q <= '0; err_q <= StatOk;
      end
      if (cmd_i.clr) row_q <= row_q + 7'd1;
    end
  end

  // x extent is tracked but never emitted
  logic unused;
  assign unused = ^ext_x_q;
endmodule
`default_nettype wire

[sv/prf_ctrl.sv]
`default_nettype none
module prf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_cmd_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire prf_pkg::dp_stat_t stat_i,
  output prf_pkg::dp_cmd_t       cmd_o
);
  import prf_pkg::*;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SSeg   = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SEmit  = 3'd4;
  localparam logic [2:0] SWait  = 3'd5;
  localparam logic [2:0] SDiv   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       last_q, last_d;

  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          if (in_cmd_i == CmdFinish) begin
            if (stat_i.err) begin
              state_d = SEmit;
            end else begin
              cmd_o.start = 1'b1;
              state_d = SRead;
            end
          end else if (!stat_i.err) begin
            if (stat_i.neg) cmd_o.err_neg = 1'b1;
            else if (stat_i.same) cmd_o.err_same = 1'b1;
            else begin
              cmd_o.load = 1'b1;
              state_d = SDiv;
            end
          end
        end
      end
      SDiv: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_done) state_d = SSeg;
      end
      SSeg: begin
        if (stat_i.seg_done) begin
          cmd_o.finish = 1'b1;
          state_d = SIdle;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d = SEmit;
      end
      SEmit: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ov_d = 1'b1;
          last_d = stat_i.err | stat_i.row_zero;
          state_d = (stat_i.err | stat_i.row_zero) ? SWait : SRead;
        end
      end
      SWait: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.clr_start = 1'b1;
          state_d = SClear;
        end
      end
      default: state_d = SClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ov_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      last_q  <= last_d;
    end
  end

  logic unused;
  assign unused = last_q;
endmodule
`default_nettype wire

[dv/tb_polyline_raster_fill_unit.sv]
`timescale 1ns / 1ps
module tb_polyline_raster_fill_unit;
  import prf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  prf_in_if  in_if ();
  prf_out_if out_if ();

  polyline_raster_fill_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Shadow copy of the block state, kept in step with each accepted vertex.
  logic [63:0] shadow_rows [64];
  logic [5:0]  shadow_px, shadow_py, shadow_ext_x, shadow_ext_y;
  logic        shadow_have_prev;
  logic [1:0]  shadow_err;

  out_item_t row_queue[$];
  int        errors = 0;
  int        rows_seen = 0;
  int        shapes_done = 0;
  int        vertices_sent = 0;
  longint    cycle_count = 0;

  // Idle and stall percentages for each phase; the long hold is a separate flag.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_sink = 1'b0;
  int unsigned hold_cycles = 0;

  task automatic clear_shadow();
    for (int r = 0; r < 64; r++) shadow_rows[r] = '0;
    shadow_px = '0;
    shadow_py = '0;
    shadow_ext_x = '0;
    shadow_ext_y = '0;
    shadow_have_prev = 1'b0;
    shadow_err = StatOk;
  endtask

  function automatic void mark_pixel(int x, int y);
    if (x >= 0 && y >= 0 && x < GridW && y < GridH) shadow_rows[y][x] = 1'b1;
  endfunction

  function automatic logic [63:0] span_of(logic [63:0] r);
    int lo;
    int hi;
    logic [63:0] span;
    lo = -1;
    hi = -1;
    span = '0;
    for (int i = 0; i < 64; i++)
      if (r[i]) begin
        if (lo < 0) lo = i;
        hi = i;
      end
    if (lo >= 0)
      for (int i = lo; i <= hi; i++) span[i] = 1'b1;
    return span;
  endfunction

  // Predict the effect of one accepted transfer; finish pushes expected rows.
  task automatic predict_item(in_item_t it);
    int x;
    int y;
    int dx;
    int dy;
    int n;
    int sx;
    int sy;
    int tx;
    int ty;
    out_item_t row;
    x = $signed(it.coord_x);
    y = $signed(it.coord_y);
    if (it.command == CmdAdd) begin
      if (shadow_err != StatOk) return;
      if (x < 0 || y < 0) begin
        shadow_err = StatNeg;
        return;
      end
      if (shadow_have_prev) begin
        dx = x - int'(shadow_px);
        dy = y - int'(shadow_py);
        if (dx != 0) n = dx < 0 ? -dx : dx;
        else if (dy != 0) n = dy < 0 ? -dy : dy;
        else begin
          shadow_err = StatSame;
          return;
        end
        // SV integer division truncates toward zero, as the datapath divider does.
        sx = dx / n;
        sy = dy / n;
        tx = shadow_px;
        ty = shadow_py;
        for (int k = 1; k < n; k++) begin
          tx += sx;
          ty += sy;
          mark_pixel(tx, ty);
        end
      end
      mark_pixel(x, y);
      if (x > shadow_ext_x) shadow_ext_x = x[5:0];
      if (y > shadow_ext_y) shadow_ext_y = y[5:0];
      shadow_px = x[5:0];
      shadow_py = y[5:0];
      shadow_have_prev = 1'b1;
      return;
    end
    if (shadow_err != StatOk) begin
      row.row_pixels = '0;
      row.row_number = '0;
      row.status = shadow_err;
      row.last_row = 1'b1;
      row_queue.push_back(row);
    end else begin
      for (int r = shadow_ext_y; r >= 0; r--) begin
        row.row_pixels = span_of(shadow_rows[r]);
        row.row_number = r[5:0];
        row.status = StatOk;
        row.last_row = (r == 0);
        row_queue.push_back(row);
      end
    end
    clear_shadow();
  endtask

  // Drive one item and wait for its transfer; predict on acceptance.
  // Valid stays high afterwards until the next call or drain drops it.
  task automatic send_item(logic cmd, int x, int y);
    in_item_t it;
    it.command = cmd;
    it.coord_x = x[6:0];
    it.coord_y = y[6:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_item(it);
    if (cmd == CmdAdd) vertices_sent++;
    else shapes_done++;
  endtask

  task automatic add_vertex(int x, int y);
    send_item(CmdAdd, x, y);
  endtask

  task automatic finish_shape();
    send_item(CmdFinish, 0, 0);
  endtask

  // Wait until every expected row is back, then let the clearing pass run.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (row_queue.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  // Receiver: random stall plus an optional long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_sink) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_sink && hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_sink <= 1'b0;
    end
  end

  // Compare every output transfer against the oldest expected row.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      rows_seen++;
      if (row_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected row, got %h", $time, out_if.data);
      end else begin
        want = row_queue.pop_front();
        if (out_if.data.row_pixels !== want.row_pixels) begin
          errors++;
          $display("%0t: row_pixels exp %h got %h", $time, want.row_pixels,
                   out_if.data.row_pixels);
        end
        if (out_if.data.row_number !== want.row_number) begin
          errors++;
          $display("%0t: row_number exp %0d got %0d", $time, want.row_number,
                   out_if.data.row_number);
        end
        if (out_if.data.status !== want.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, want.status,
                   out_if.data.status);
        end
        if (out_if.data.last_row !== want.last_row) begin
          errors++;
          $display("%0t: last_row exp %0b got %0b", $time, want.last_row,
                   out_if.data.last_row);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Corners, horizontal, vertical and sloped segments, error cases.
  task automatic test_directed();
    finish_shape();                    // empty shape
    add_vertex(0, 0);
    add_vertex(63, 0);
    add_vertex(63, 63);
    add_vertex(0, 63);
    add_vertex(0, 0);
    finish_shape();
    add_vertex(10, 5);
    add_vertex(3, 20);                 // steep, truncated step
    add_vertex(30, 22);
    add_vertex(30, 2);                 // vertical
    finish_shape();
    add_vertex(5, 5);
    add_vertex(-64, 7);                // negative x
    add_vertex(8, 8);                  // ignored under error
    finish_shape();
    add_vertex(4, -1);                 // negative y
    finish_shape();
    add_vertex(9, 9);
    add_vertex(9, 9);                  // coincident
    add_vertex(-3, 2);                 // first error stays
    finish_shape();
    drain();
  endtask

  // Random shapes; mostly well formed, a few with errors.
  task automatic test_random_shapes(int unsigned n_items);
    int unsigned sent;
    int nv;
    int x;
    int y;
    sent = 0;
    while (sent < n_items) begin
      nv = $urandom_range(1, 6);
      for (int v = 0; v < nv; v++) begin
        if ($urandom_range(99) < 4) begin
          x = $signed(7'($urandom));
          y = $signed(7'($urandom));
        end else if ($urandom_range(99) < 70) begin
          x = $urandom_range(0, 20);
          y = $urandom_range(0, 12);
        end else begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end
        if ($urandom_range(99) < 3) begin
          x = shadow_px;
          y = shadow_py;
        end
        add_vertex(x, y);
        sent++;
      end
      finish_shape();
      sent++;
    end
  endtask

  // Long receiver hold while the sender keeps going, then a full pause.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    hold_sink = 1'b1;
    add_vertex(0, 2);
    add_vertex(6, 0);
    finish_shape();
    add_vertex(1, 1);
    add_vertex(5, 3);
    finish_shape();
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    clear_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (80) @(posedge clk_i);      // clearing pass after reset
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_shapes(100); drain();
    send_idle_pct = 57; recv_stall_pct = 0;  test_random_shapes(90);  drain();
    send_idle_pct = 0;  recv_stall_pct = 57; test_random_shapes(90);  drain();
    send_idle_pct = 24; recv_stall_pct = 24; test_random_shapes(100); drain();
    test_backpressure();
    $display("Covered %0d vertices and %0d finish commands, %0d rows checked.",
             vertices_sent, shapes_done, rows_seen);
    if (errors == 0 && row_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
